// ===== src/jds_pkg.sv =====
// ----------------------------------------------------------------------------
// jds_pkg
// Shared types, sizes and helpers for the job dependency scoreboard.
// ----------------------------------------------------------------------------
package jds_pkg;

  // Table geometry
  localparam int ENTRIES     = 32;
  localparam int JOB_ID_BITS = 8;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int STAMP_W     = 16;

  // Port widths fixed by the interface
  localparam int PORT_ID_W = 8;
  localparam int CMD_W     = 3;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FINISH = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_LIST   = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture the input request
    logic exec;        // single-result command: update table, write result
    logic list_start;  // begin a list: clear taken marks and scan state
    logic scan_step;   // examine one table slot
    logic emit;        // write one list result, mark its slot taken
  } jds_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic list_go;     // list request with at least one prerequisite
    logic scan_end;    // scan is at the last slot
    logic emit_last;   // pending list result is the final one
  } jds_sts_t;

  // Port id to internal id (low JOB_ID_BITS bits, zero extended)
  function automatic logic [JOB_ID_BITS-1:0] to_id(input logic [PORT_ID_W-1:0] x);
    logic [15:0] ext;
    ext = {8'b0, x};
    return ext[JOB_ID_BITS-1:0];
  endfunction

  // Internal id back to port width
  function automatic logic [PORT_ID_W-1:0] to_port(input logic [JOB_ID_BITS-1:0] x);
    logic [15:0] ext;
    ext = 16'(x);
    return ext[PORT_ID_W-1:0];
  endfunction

endpackage

// ===== src/jds_ctrl.sv =====
// ----------------------------------------------------------------------------
// jds_ctrl
// Sequencer: takes one request at a time, runs single-result commands in one
// step and walks list requests through scan and emit rounds.
// ----------------------------------------------------------------------------
module jds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  jds_pkg::jds_sts_t sts_i,
  output jds_pkg::jds_cmd_t cmd_o
);

  jds_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jds_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jds_pkg::S_IDLE: begin
        if (in_valid_i) state_d = jds_pkg::S_EXEC;
      end
      jds_pkg::S_EXEC: begin
        if (sts_i.list_go) state_d = jds_pkg::S_SCAN;
        else if (sts_i.out_free) state_d = jds_pkg::S_IDLE;
      end
      jds_pkg::S_SCAN: begin
        if (sts_i.scan_end) state_d = jds_pkg::S_EMIT;
      end
      jds_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.emit_last ? jds_pkg::S_IDLE : jds_pkg::S_SCAN;
        end
      end
      default: state_d = jds_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      jds_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      jds_pkg::S_EXEC: begin
        cmd_o.list_start = sts_i.list_go;
        cmd_o.exec       = !sts_i.list_go && sts_i.out_free;
      end
      jds_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      jds_pkg::S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== src/jds_dp.sv =====
// ----------------------------------------------------------------------------
// jds_dp
// Datapath: dependency table with parallel match, request registers,
// newest-first scan unit and the output register.
// ----------------------------------------------------------------------------
module jds_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [jds_pkg::CMD_W-1:0]          cmd_i,
  input  logic [jds_pkg::PORT_ID_W-1:0]      job_a_i,
  input  logic [jds_pkg::PORT_ID_W-1:0]      job_b_i,
  input  logic                               succeeded_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic                               found_o,
  output logic                               dep_valid_o,
  output logic [jds_pkg::PORT_ID_W-1:0]      dep_job_o,
  output logic                               last_o,
  input  jds_pkg::jds_cmd_t                  cmd_ctl_i,
  output jds_pkg::jds_sts_t                  sts_o
);

  localparam int N  = jds_pkg::ENTRIES;
  localparam int IW = jds_pkg::IDX_W;
  localparam int JW = jds_pkg::JOB_ID_BITS;
  localparam int SW = jds_pkg::STAMP_W;

  // Table
  logic [N-1:0]  valid_q;
  logic [JW-1:0] waiter_q [N];
  logic [JW-1:0] prereq_q [N];
  logic [SW-1:0] age_q    [N];
  logic [SW-1:0] stamp_q;

  // Request
  logic [jds_pkg::CMD_W-1:0] cmd_q;
  logic [JW-1:0]             a_q, b_q;
  logic                      ok_q;

  // Scan
  logic [N-1:0]  taken_q;
  logic [IW-1:0] idx_q, best_q;
  logic [SW-1:0] bestd_q;
  logic          have_q;

  // Output register
  logic                          out_valid_q;
  logic [1:0]                    status_q;
  logic                          found_q, dep_valid_q, last_q;
  logic [jds_pkg::PORT_ID_W-1:0] dep_job_q;

  // Match vectors
  logic [N-1:0]  wmatch, pmatch, fmatch, cand, best_oh;
  logic [IW-1:0] free_idx, rm_idx;
  logic          have_free, have_rm;

  always_comb begin
    free_idx  = '0;
    rm_idx    = '0;
    have_free = 1'b0;
    have_rm   = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      wmatch[i]  = valid_q[i] && (waiter_q[i] == a_q);
      pmatch[i]  = wmatch[i] && (prereq_q[i] == b_q);
      fmatch[i]  = valid_q[i] && (prereq_q[i] == a_q);
      cand[i]    = wmatch[i] && !taken_q[i];
      best_oh[i] = (IW'(i) == best_q);
      if (!valid_q[i]) begin
        free_idx  = IW'(i);
        have_free = 1'b1;
      end
      if (pmatch[i]) begin
        rm_idx  = IW'(i);
        have_rm = 1'b1;
      end
    end
  end

  // Single-result command decode
  logic    a_zero, pair_bad;
  logic    do_add, do_rm, do_fin, res_found;
  jds_pkg::status_e res_status;

  assign a_zero   = (a_q == '0);
  assign pair_bad = a_zero || (b_q == '0) || (a_q == b_q);

  always_comb begin
    res_status = jds_pkg::ST_OK;
    res_found  = 1'b0;
    do_add     = 1'b0;
    do_rm      = 1'b0;
    do_fin     = 1'b0;
    case (cmd_q)
      jds_pkg::CMD_ADD: begin
        if (pair_bad) res_status = jds_pkg::ST_INVALID;
        else if (!have_free) res_status = jds_pkg::ST_FULL;
        else do_add = 1'b1;
      end
      jds_pkg::CMD_REMOVE: begin
        if (pair_bad) begin
          res_status = jds_pkg::ST_INVALID;
        end else begin
          do_rm     = have_rm;
          res_found = have_rm;
        end
      end
      jds_pkg::CMD_FINISH: begin
        if (a_zero) res_status = jds_pkg::ST_INVALID;
        else do_fin = ok_q;
      end
      jds_pkg::CMD_QUERY: begin
        if (a_zero) res_status = jds_pkg::ST_INVALID;
        else res_found = !(|wmatch);
      end
      jds_pkg::CMD_LIST: begin
        if (a_zero) res_status = jds_pkg::ST_INVALID;
      end
      default: res_status = jds_pkg::ST_INVALID;
    endcase
  end

  // Scan distance for the current slot (wrapping age distance)
  logic [SW-1:0] d_cur;
  logic          take_cur;
  assign d_cur    = stamp_q - age_q[idx_q];
  assign take_cur = cand[idx_q] && (!have_q || (d_cur < bestd_q));

  // Status to controller
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.list_go   = (cmd_q == jds_pkg::CMD_LIST) && !a_zero && (|wmatch);
  assign sts_o.scan_end  = (idx_q == IW'(N - 1));
  assign sts_o.emit_last = ((cand & ~best_oh) == '0);

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.load) begin
      cmd_q <= cmd_i;
      a_q   <= jds_pkg::to_id(job_a_i);
      b_q   <= jds_pkg::to_id(job_b_i);
      ok_q  <= succeeded_i;
    end
  end

  // Valid bits and insert stamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      stamp_q <= '0;
    end else if (cmd_ctl_i.exec) begin
      if (do_add) begin
        valid_q[free_idx] <= 1'b1;
        stamp_q           <= stamp_q + SW'(1);
      end
      if (do_rm) valid_q[rm_idx] <= 1'b0;
      if (do_fin) valid_q <= valid_q & ~fmatch;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.exec && do_add) begin
      waiter_q[free_idx] <= a_q;
      prereq_q[free_idx] <= b_q;
      age_q[free_idx]    <= stamp_q;
    end
  end

  // Newest-first selection, one slot per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
      idx_q   <= '0;
      best_q  <= '0;
      bestd_q <= '0;
      have_q  <= 1'b0;
    end else if (cmd_ctl_i.list_start) begin
      taken_q <= '0;
      idx_q   <= '0;
      have_q  <= 1'b0;
    end else if (cmd_ctl_i.scan_step) begin
      idx_q <= idx_q + IW'(1);
      if (take_cur) begin
        best_q  <= idx_q;
        bestd_q <= d_cur;
        have_q  <= 1'b1;
      end
    end else if (cmd_ctl_i.emit) begin
      taken_q <= taken_q | best_oh;
      idx_q   <= '0;
      have_q  <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ctl_i.exec || cmd_ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.exec) begin
      status_q    <= res_status;
      found_q     <= res_found;
      dep_valid_q <= 1'b0;
      dep_job_q   <= '0;
      last_q      <= 1'b1;
    end else if (cmd_ctl_i.emit) begin
      status_q    <= jds_pkg::ST_OK;
      found_q     <= 1'b0;
      dep_valid_q <= 1'b1;
      dep_job_q   <= jds_pkg::to_port(prereq_q[best_q]);
      last_q      <= sts_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign dep_valid_o = dep_valid_q;
  assign dep_job_o   = dep_job_q;
  assign last_o      = last_q;

endmodule

// ===== src/job_dependency_scoreboard_top.sv =====
// ----------------------------------------------------------------------------
// job_dependency_scoreboard_top
// Job dependency scoreboard: add, remove, finish, can-run query and
// newest-first prerequisite list over a table of dependency pairs.
// ----------------------------------------------------------------------------
// Add, remove, finish, query: the request is captured on accept and executed
// once the output register is free; no new request is taken until then.
// List: after setup, each prerequisite is found by a slot-by-slot age scan
// over the whole table and then emitted; no new request is taken meanwhile.
// A new request is taken while the last result still waits in the output
// register. Reset (rst_ni low) empties the table and clears the stamp.
// ----------------------------------------------------------------------------
module job_dependency_scoreboard_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [jds_pkg::CMD_W-1:0]     cmd_i,
  input  logic [jds_pkg::PORT_ID_W-1:0] job_a_i,
  input  logic [jds_pkg::PORT_ID_W-1:0] job_b_i,
  input  logic                          succeeded_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic                          found_o,
  output logic                          dep_valid_o,
  output logic [jds_pkg::PORT_ID_W-1:0] dep_job_o,
  output logic                          last_o
);

  jds_pkg::jds_cmd_t ctl_cmd;
  jds_pkg::jds_sts_t dp_sts;

  // Sequencer
  jds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  // Table and result path
  jds_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .job_a_i     (job_a_i),
    .job_b_i     (job_b_i),
    .succeeded_i (succeeded_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .found_o     (found_o),
    .dep_valid_o (dep_valid_o),
    .dep_job_o   (dep_job_o),
    .last_o      (last_o),
    .cmd_ctl_i   (ctl_cmd),
    .sts_o       (dp_sts)
  );

endmodule
